// ----- rtl/tfl_pkg.sv -----
// Shared types and register indexes for the torque foldback limiter.
package tfl_pkg;

   typedef enum logic [2:0] {
      REGION_FULL = 3'b001,
      REGION_ZERO = 3'b010,
      REGION_RAMP = 3'b100
   } region_type;

   typedef struct packed {
      logic       valid;
      logic       enable;
      region_type region;
   } ctl_type;

   localparam int CSR_INDEX_WIDTH = 2;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_ENABLE = 2'd0,
      CSR_START  = 2'd1,
      CSR_END    = 2'd2,
      CSR_FULL   = 2'd3
   } csr_index_type;

endpackage

// ----- rtl/tfl_prep.sv -----
// Region classification, span and distance stage, then the limit multiply stage.
module tfl_prep import tfl_pkg::*; #(
   parameter int DATA_WIDTH = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        advance,
   input  logic                        up_valid,
   input  logic [DATA_WIDTH-1:0]       up_req,
   input  logic [DATA_WIDTH-1:0]       up_measured,
   input  logic                        cfg_enable,
   input  logic [DATA_WIDTH-1:0]       cfg_start,
   input  logic [DATA_WIDTH-1:0]       cfg_end,
   input  logic [DATA_WIDTH-2:0]       cfg_full,
   output ctl_type                     dn_ctl,
   output logic [DATA_WIDTH-1:0]       dn_req,
   output logic [DATA_WIDTH-2:0]       dn_full,
   output logic [DATA_WIDTH-1:0]       dn_span,
   output logic [2*DATA_WIDTH-2:0]     dn_product
);

   localparam int W = DATA_WIDTH;

   logic signed [W:0]   s_x;
   logic signed [W:0]   e_x;
   logic signed [W:0]   x_x;
   logic signed [W:0]   e_minus_s;
   logic signed [W:0]   s_minus_e;
   logic signed [W:0]   e_minus_x;
   logic signed [W:0]   x_minus_e;

   ctl_type             ctl1_in, ctl1_ff;
   logic [W-1:0]        req1_ff;
   logic [W-2:0]        full1_ff;
   logic [W-1:0]        span1_in, span1_ff;
   logic [W-1:0]        dist1_in, dist1_ff;

   ctl_type             ctl2_ff;
   logic [W-1:0]        req2_ff;
   logic [W-2:0]        full2_ff;
   logic [W-1:0]        span2_ff;
   logic [2*W-2:0]      product2_in, product2_ff;

   assign s_x       = signed'({cfg_start[W-1], cfg_start});
   assign e_x       = signed'({cfg_end[W-1], cfg_end});
   assign x_x       = signed'({up_measured[W-1], up_measured});
   assign e_minus_s = e_x - s_x;
   assign s_minus_e = s_x - e_x;
   assign e_minus_x = e_x - x_x;
   assign x_minus_e = x_x - e_x;

   always_comb begin
      ctl1_in.valid  = up_valid;
      ctl1_in.enable = cfg_enable;
      ctl1_in.region = REGION_ZERO;
      span1_in       = '0;
      dist1_in       = '0;
      if (s_x <= e_x) begin
         span1_in = e_minus_s[W-1:0];
         priority if (x_x <= s_x) begin
            ctl1_in.region = REGION_FULL;
         end else if (x_x >= e_x) begin
            ctl1_in.region = REGION_ZERO;
         end else begin
            ctl1_in.region = REGION_RAMP;
            dist1_in       = e_minus_x[W-1:0];
         end
      end else begin
         span1_in = s_minus_e[W-1:0];
         priority if (x_x >= s_x) begin
            ctl1_in.region = REGION_FULL;
         end else if (x_x <= e_x) begin
            ctl1_in.region = REGION_ZERO;
         end else begin
            ctl1_in.region = REGION_RAMP;
            dist1_in       = x_minus_e[W-1:0];
         end
      end
   end

   assign product2_in = full1_ff * dist1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl1_ff.valid <= 1'b0;
         ctl2_ff.valid <= 1'b0;
      end else if (advance) begin
         ctl1_ff.valid <= ctl1_in.valid;
         ctl2_ff.valid <= ctl1_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         ctl1_ff.enable <= ctl1_in.enable;
         ctl1_ff.region <= ctl1_in.region;
         req1_ff        <= up_req;
         full1_ff       <= cfg_full;
         span1_ff       <= span1_in;
         dist1_ff       <= dist1_in;
         ctl2_ff.enable <= ctl1_ff.enable;
         ctl2_ff.region <= ctl1_ff.region;
         req2_ff        <= req1_ff;
         full2_ff       <= full1_ff;
         span2_ff       <= span1_ff;
         product2_ff    <= product2_in;
      end
   end

   assign dn_ctl     = ctl2_ff;
   assign dn_req     = req2_ff;
   assign dn_full    = full2_ff;
   assign dn_span    = span2_ff;
   assign dn_product = product2_ff;

   a_ramp_dist_below_span: assert property (
      @(posedge clock) disable iff (reset)
      (ctl1_ff.valid && ctl1_ff.region == REGION_RAMP) |-> (dist1_ff < span1_ff)
   ) else $error("ramp distance not below span");

endmodule

// ----- rtl/tfl_div_step.sv -----
// One restoring division step of the limit quotient, with its pipeline register.
module tfl_div_step import tfl_pkg::*; #(
   parameter int DATA_WIDTH = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  ctl_type               up_ctl,
   input  logic [DATA_WIDTH-1:0] up_req,
   input  logic [DATA_WIDTH-2:0] up_full,
   input  logic [DATA_WIDTH-1:0] up_span,
   input  logic [DATA_WIDTH-1:0] up_rem,
   input  logic [DATA_WIDTH-2:0] up_low,
   output ctl_type               dn_ctl,
   output logic [DATA_WIDTH-1:0] dn_req,
   output logic [DATA_WIDTH-2:0] dn_full,
   output logic [DATA_WIDTH-1:0] dn_span,
   output logic [DATA_WIDTH-1:0] dn_rem,
   output logic [DATA_WIDTH-2:0] dn_low
);

   localparam int W = DATA_WIDTH;

   logic [W:0]   trial;
   logic [W:0]   diff;
   logic         take;
   logic [W-1:0] rem_in;
   logic [W-2:0] low_in;

   ctl_type      ctl_ff;
   logic [W-1:0] req_ff;
   logic [W-2:0] full_ff;
   logic [W-1:0] span_ff;
   logic [W-1:0] rem_ff;
   logic [W-2:0] low_ff;

   assign trial  = {up_rem, up_low[W-2]};
   assign diff   = trial - {1'b0, up_span};
   assign take   = (trial >= {1'b0, up_span});
   assign rem_in = take ? diff[W-1:0] : trial[W-1:0];
   assign low_in = {up_low[W-3:0], take};

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.valid <= 1'b0;
      end else if (advance) begin
         ctl_ff.valid <= up_ctl.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         ctl_ff.enable <= up_ctl.enable;
         ctl_ff.region <= up_ctl.region;
         req_ff        <= up_req;
         full_ff       <= up_full;
         span_ff       <= up_span;
         rem_ff        <= rem_in;
         low_ff        <= low_in;
      end
   end

   assign dn_ctl  = ctl_ff;
   assign dn_req  = req_ff;
   assign dn_full = full_ff;
   assign dn_span = span_ff;
   assign dn_rem  = rem_ff;
   assign dn_low  = low_ff;

   a_rem_below_span: assert property (
      @(posedge clock) disable iff (reset)
      ctl_ff.valid |-> ((rem_ff < span_ff) || (span_ff == '0))
   ) else $error("partial remainder not below span");

endmodule

// ----- rtl/tfl_clamp.sv -----
// Limit selection, symmetric torque clamp and output register.
module tfl_clamp import tfl_pkg::*; #(
   parameter int DATA_WIDTH = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  ctl_type               up_ctl,
   input  logic [DATA_WIDTH-1:0] up_req,
   input  logic [DATA_WIDTH-2:0] up_full,
   input  logic [DATA_WIDTH-2:0] up_quot,
   output logic                  rsp_valid,
   output logic [DATA_WIDTH-1:0] rsp_limited_torque,
   output logic [DATA_WIDTH-2:0] rsp_torque_limit
);

   localparam int W = DATA_WIDTH;

   logic [W-2:0]      lim_in;
   logic signed [W:0] req_x;
   logic signed [W:0] lim_x;
   logic signed [W:0] neg_lim_x;
   logic [W-1:0]      res_in;

   logic              valid_ff;
   logic [W-1:0]      res_ff;
   logic [W-2:0]      lim_ff;

   logic signed [W:0] res_chk;
   logic signed [W:0] lim_chk;

   always_comb begin
      lim_in = '0;
      if (up_ctl.enable) begin
         unique case (up_ctl.region)
            REGION_FULL: lim_in = up_full;
            REGION_ZERO: lim_in = '0;
            REGION_RAMP: lim_in = up_quot;
            default:     lim_in = '0;
         endcase
      end
   end

   assign req_x     = signed'({up_req[W-1], up_req});
   assign lim_x     = signed'({2'b00, lim_in});
   assign neg_lim_x = -lim_x;

   always_comb begin
      res_in = up_req;
      if (up_ctl.enable) begin
         priority if (req_x > lim_x) begin
            res_in = lim_x[W-1:0];
         end else if (req_x < neg_lim_x) begin
            res_in = neg_lim_x[W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= up_ctl.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         res_ff <= res_in;
         lim_ff <= lim_in;
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_limited_torque = res_ff;
   assign rsp_torque_limit   = lim_ff;

   assign res_chk = signed'({res_ff[W-1], res_ff});
   assign lim_chk = signed'({2'b00, lim_ff});

   a_result_within_limit: assert property (
      @(posedge clock) disable iff (reset)
      (valid_ff && lim_ff != '0) |-> ((res_chk <= lim_chk) && (res_chk >= -lim_chk))
   ) else $error("limited torque outside the reported limit");

endmodule

// ----- rtl/torque_foldback_limiter.sv -----
// Top level of the torque foldback limiter: configuration registers and pipeline.
//
// Usage:
//   Input channel req_* carries a requested torque and a measured value (signed).
//   Result channel rsp_* returns the torque clamped to +/- the foldback limit and
//   the limit itself (zero when disabled). Both channels use valid/ready.
//   The csr_* port writes enable, start, end and full torque; write only while
//   no transaction is in flight.
// Pipeline: one classification stage, one multiply stage, DATA_WIDTH - 1 restoring
//   division stages (one quotient bit each) and one clamp/output stage.
// Throughput: one transaction per cycle outside stalls; every stage holds one.
// Reset: synchronous; clears all valid bits and all configuration registers,
//   so the block comes up disabled and passes torque through.
// Stall: while rsp_valid is high and rsp_ready low, the whole pipeline holds and
//   req_ready drops; nothing is dropped or repeated.
module torque_foldback_limiter import tfl_pkg::*; #(
   parameter int DATA_WIDTH = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [DATA_WIDTH-1:0]      req_requested_torque,
   input  logic [DATA_WIDTH-1:0]      req_measured_value,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [DATA_WIDTH-1:0]      rsp_limited_torque,
   output logic [DATA_WIDTH-2:0]      rsp_torque_limit,
   input  logic                       csr_we,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [DATA_WIDTH-1:0]      csr_wdata
);

   localparam int W = DATA_WIDTH;

   logic          advance;

   logic          enable_ff;
   logic [W-1:0]  start_ff;
   logic [W-1:0]  end_ff;
   logic [W-2:0]  full_ff;

   ctl_type       ctl_s  [0:W-1];
   logic [W-1:0]  req_s  [0:W-1];
   logic [W-2:0]  full_s [0:W-1];
   logic [W-1:0]  span_s [0:W-1];
   logic [W-1:0]  rem_s  [0:W-1];
   logic [W-2:0]  low_s  [0:W-1];
   logic [2*W-2:0] product;

   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b0;
         start_ff  <= '0;
         end_ff    <= '0;
         full_ff   <= '0;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_ENABLE: enable_ff <= csr_wdata[0];
            CSR_START:  start_ff  <= csr_wdata;
            CSR_END:    end_ff    <= csr_wdata;
            CSR_FULL:   full_ff   <= csr_wdata[W-2:0];
            default:    ;
         endcase
      end
   end

   tfl_prep #(.DATA_WIDTH(W)) u_prep (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .up_valid    (req_valid),
      .up_req      (req_requested_torque),
      .up_measured (req_measured_value),
      .cfg_enable  (enable_ff),
      .cfg_start   (start_ff),
      .cfg_end     (end_ff),
      .cfg_full    (full_ff),
      .dn_ctl      (ctl_s[0]),
      .dn_req      (req_s[0]),
      .dn_full     (full_s[0]),
      .dn_span     (span_s[0]),
      .dn_product  (product)
   );

   assign rem_s[0] = product[2*W-2:W-1];
   assign low_s[0] = product[W-2:0];

   for (genvar k = 1; k < W; k++) begin : g_div
      tfl_div_step #(.DATA_WIDTH(W)) u_step (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .up_ctl  (ctl_s[k-1]),
         .up_req  (req_s[k-1]),
         .up_full (full_s[k-1]),
         .up_span (span_s[k-1]),
         .up_rem  (rem_s[k-1]),
         .up_low  (low_s[k-1]),
         .dn_ctl  (ctl_s[k]),
         .dn_req  (req_s[k]),
         .dn_full (full_s[k]),
         .dn_span (span_s[k]),
         .dn_rem  (rem_s[k]),
         .dn_low  (low_s[k])
      );
   end

   tfl_clamp #(.DATA_WIDTH(W)) u_clamp (
      .clock              (clock),
      .reset              (reset),
      .advance            (advance),
      .up_ctl             (ctl_s[W-1]),
      .up_req             (req_s[W-1]),
      .up_full            (full_s[W-1]),
      .up_quot            (low_s[W-1]),
      .rsp_valid          (rsp_valid),
      .rsp_limited_torque (rsp_limited_torque),
      .rsp_torque_limit   (rsp_torque_limit)
   );

   a_stall_freezes_pipe: assert property (
      @(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> ($stable(ctl_s[W-1]) && $stable(low_s[W-1]))
   ) else $error("pipeline moved during output stall");

endmodule

// ----- dv/torque_limit_checker.sv -----
// Checker for the torque foldback limiter: predicts each result and compares it.
module torque_limit_checker import tfl_pkg::*; #(
   parameter int DATA_WIDTH = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  logic [DATA_WIDTH-1:0]               req_requested_torque,
   input  logic [DATA_WIDTH-1:0]               req_measured_value,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  logic [DATA_WIDTH-1:0]               rsp_limited_torque,
   input  logic [DATA_WIDTH-2:0]               rsp_torque_limit,
   input  logic                                csr_we,
   input  logic [tfl_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [DATA_WIDTH-1:0]               csr_wdata,
   output int                                  fail_count,
   output int                                  outstanding
);

   typedef struct packed {
      logic [DATA_WIDTH-1:0] limited_torque;
      logic [DATA_WIDTH-2:0] torque_limit;
   } torque_result_type;

   torque_result_type            expected_torques[$];
   logic                         cfg_enable;
   logic signed [DATA_WIDTH-1:0] cfg_start;
   logic signed [DATA_WIDTH-1:0] cfg_end;
   logic [DATA_WIDTH-2:0]        cfg_full;
   int                           errors = 0;

   function automatic longint derated_limit(longint measured);
      longint s;
      longint e;
      longint full;
      s = longint'(cfg_start);
      e = longint'(cfg_end);
      full = longint'(cfg_full);
      if (s <= e) begin
         if (measured <= s) return full;
         if (measured >= e) return 0;
         return full * (e - measured) / (e - s);
      end
      if (measured >= s) return full;
      if (measured <= e) return 0;
      return full * (measured - e) / (s - e);
   endfunction

   function automatic torque_result_type predict_clamp(logic [DATA_WIDTH-1:0] torque,
                                                       logic [DATA_WIDTH-1:0] measured);
      torque_result_type result;
      longint            command;
      longint            ceiling;
      longint            clamped;
      command = longint'($signed(torque));
      ceiling = 0;
      clamped = command;
      if (cfg_enable) begin
         ceiling = derated_limit(longint'($signed(measured)));
         if (command > ceiling)
            clamped = ceiling;
         else if (command < -ceiling)
            clamped = -ceiling;
      end
      result.limited_torque = clamped[DATA_WIDTH-1:0];
      result.torque_limit = ceiling[DATA_WIDTH-2:0];
      return result;
   endfunction

   always @(posedge clock) begin : watch_channels
      torque_result_type predicted;
      torque_result_type observed;
      if (reset) begin
         cfg_enable = 1'b0;
         cfg_start = '0;
         cfg_end = '0;
         cfg_full = '0;
         expected_torques.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_ENABLE: cfg_enable = csr_wdata[0];
               CSR_START:  cfg_start = csr_wdata;
               CSR_END:    cfg_end = csr_wdata;
               CSR_FULL:   cfg_full = csr_wdata[DATA_WIDTH-2:0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            observed.limited_torque = rsp_limited_torque;
            observed.torque_limit = rsp_torque_limit;
            if (expected_torques.size() == 0) begin
               $error("unexpected transaction: limited_torque %0d, torque_limit %0d",
                      $signed(observed.limited_torque), observed.torque_limit);
               errors++;
            end else begin
               predicted = expected_torques.pop_front();
               if (observed.limited_torque !== predicted.limited_torque) begin
                  $error("limited_torque mismatch: expected %0d, actual %0d",
                         $signed(predicted.limited_torque), $signed(observed.limited_torque));
                  errors++;
               end
               if (observed.torque_limit !== predicted.torque_limit) begin
                  $error("torque_limit mismatch: expected %0d, actual %0d",
                         predicted.torque_limit, observed.torque_limit);
                  errors++;
               end
            end
         end
         if (req_valid && req_ready)
            expected_torques.push_back(predict_clamp(req_requested_torque, req_measured_value));
      end
      fail_count <= errors;
      outstanding <= expected_torques.size();
   end

endmodule

// ----- dv/tb_torque_foldback_limiter.sv -----
// Testbench top for the torque foldback limiter: stimulus, configuration and verdict.
module tb_torque_foldback_limiter import tfl_pkg::*;;

   localparam int DATA_WIDTH = 16;
   localparam int TORQUE_MAX = 2 ** (DATA_WIDTH - 1) - 1;
   localparam int TORQUE_MIN = -(2 ** (DATA_WIDTH - 1));
   localparam int LONG_HOLD_CYCLES = 80;
   localparam int PHASE_COUNT = 11;
   localparam int PHASE_ITEMS = 150;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic [DATA_WIDTH-1:0]      req_requested_torque = '0;
   logic [DATA_WIDTH-1:0]      req_measured_value = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic [DATA_WIDTH-1:0]      rsp_limited_torque;
   logic [DATA_WIDTH-2:0]      rsp_torque_limit;
   logic                       csr_we = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = CSR_ENABLE;
   logic [DATA_WIDTH-1:0]      csr_wdata = '0;
   int                         fail_count;
   int                         outstanding;

   bit idle_off = 1'b0;
   int hold_requests = 0;
   int cfg_start = 0;
   int cfg_end = 0;
   int cfg_full = 0;

   torque_foldback_limiter #(.DATA_WIDTH(DATA_WIDTH)) u_dut (.*);

   torque_limit_checker #(.DATA_WIDTH(DATA_WIDTH)) u_checker (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   initial begin
      #(12 * 400000);
      $display("CHECK FAILED");
      $finish;
   end

   initial begin : rsp_side
      int stall_left;
      int hold_served;
      stall_left = 0;
      hold_served = 0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else if (hold_served != hold_requests) begin
            hold_served++;
            stall_left = LONG_HOLD_CYCLES - 1;
            rsp_ready <= 1'b0;
         end else if (!idle_off && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(1, 5) - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   function automatic int clamp_word(int value);
      if (value < TORQUE_MIN) return TORQUE_MIN;
      if (value > TORQUE_MAX) return TORQUE_MAX;
      return value;
   endfunction

   function automatic int random_word();
      logic signed [DATA_WIDTH-1:0] raw;
      raw = DATA_WIDTH'($urandom);
      return int'(raw);
   endfunction

   function automatic int pick_measured();
      int lo;
      int hi;
      lo = (cfg_start < cfg_end) ? cfg_start : cfg_end;
      hi = (cfg_start < cfg_end) ? cfg_end : cfg_start;
      case ($urandom_range(0, 5))
         0, 1: return lo + int'($urandom_range(0, hi - lo));
         2: return clamp_word(cfg_start + int'($urandom_range(0, 4)) - 2);
         3: return clamp_word(cfg_end + int'($urandom_range(0, 4)) - 2);
         4: return $urandom_range(0, 1) ? TORQUE_MAX : TORQUE_MIN;
         default: return random_word();
      endcase
   endfunction

   function automatic int pick_torque();
      int edge_value;
      case ($urandom_range(0, 4))
         0: return random_word();
         1: begin
            case ($urandom_range(0, 3))
               0: return TORQUE_MAX;
               1: return TORQUE_MIN;
               2: return 0;
               default: return -1;
            endcase
         end
         2: begin
            edge_value = cfg_full + int'($urandom_range(0, 4)) - 2;
            return clamp_word($urandom_range(0, 1) ? edge_value : -edge_value);
         end
         default: return clamp_word(int'($urandom_range(0, 2 * cfg_full + 20)) - cfg_full - 10);
      endcase
   endfunction

   task automatic push_transaction(int torque, int measured);
      int gap;
      @(negedge clock);
      req_valid <= 1'b1;
      req_requested_torque <= torque[DATA_WIDTH-1:0];
      req_measured_value <= measured[DATA_WIDTH-1:0];
      do @(posedge clock); while (!req_ready);
      if (!idle_off && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 5);
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic drain_pipe();
      @(negedge clock);
      req_valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
   endtask

   task automatic write_reg(csr_index_type index, logic [DATA_WIDTH-1:0] data);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic configure(bit enable, int start_point, int end_point, int full);
      logic [DATA_WIDTH-1:0] word;
      drain_pipe();
      word = DATA_WIDTH'($urandom);
      word[0] = enable;
      write_reg(CSR_ENABLE, word);
      write_reg(CSR_START, start_point[DATA_WIDTH-1:0]);
      write_reg(CSR_END, end_point[DATA_WIDTH-1:0]);
      word = full[DATA_WIDTH-1:0];
      word[DATA_WIDTH-1] = 1'($urandom_range(0, 1));
      write_reg(CSR_FULL, word);
      cfg_start = start_point;
      cfg_end = end_point;
      cfg_full = full;
   endtask

   initial begin : stimulus
      bit enable;
      int start_point;
      int end_point;
      int full;

      repeat (6) @(negedge clock);
      reset <= 1'b0;

      // disabled after reset: pass through
      push_transaction(TORQUE_MAX, 0);
      push_transaction(TORQUE_MIN, TORQUE_MIN);
      push_transaction(1234, TORQUE_MAX);

      // normal curve
      configure(1'b1, -100, 100, TORQUE_MAX);
      push_transaction(TORQUE_MAX, TORQUE_MIN);
      push_transaction(TORQUE_MIN, -100);
      push_transaction(TORQUE_MAX, 0);
      push_transaction(TORQUE_MIN, 50);
      push_transaction(100, 100);
      push_transaction(-5, TORQUE_MAX);

      // inverted curve
      configure(1'b1, 100, -100, 1000);
      push_transaction(5000, TORQUE_MAX);
      push_transaction(-5000, 100);
      push_transaction(5000, 0);
      push_transaction(-700, -99);
      push_transaction(3, -100);

      // equal start and end
      configure(1'b1, -5, -5, 20000);
      push_transaction(30000, -5);
      push_transaction(-30000, -6);
      push_transaction(30000, -4);

      // widest spans, both directions, then zero full torque
      configure(1'b1, TORQUE_MIN, TORQUE_MAX, TORQUE_MAX);
      push_transaction(TORQUE_MAX, 0);
      push_transaction(TORQUE_MIN, TORQUE_MAX - 1);
      configure(1'b1, TORQUE_MAX, TORQUE_MIN, TORQUE_MAX);
      push_transaction(TORQUE_MAX, TORQUE_MIN + 1);
      push_transaction(TORQUE_MIN, 0);
      configure(1'b1, TORQUE_MAX, TORQUE_MIN, 0);
      push_transaction(1, 0);
      push_transaction(-1, 0);

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         enable = 1'b1;
         start_point = random_word();
         end_point = random_word();
         full = $urandom_range(0, TORQUE_MAX);
         case (phase)
            0: begin
               start_point = TORQUE_MIN;
               end_point = TORQUE_MAX;
               full = TORQUE_MAX;
            end
            1: begin
               start_point = TORQUE_MAX;
               end_point = TORQUE_MIN;
               full = TORQUE_MAX;
            end
            2: enable = 1'b0;
            3: end_point = start_point;
            5: end_point = clamp_word(start_point + int'($urandom_range(1, 64)));
            6: end_point = clamp_word(start_point - int'($urandom_range(1, 64)));
            7: full = $urandom_range(0, 3);
            default: ;
         endcase
         configure(enable, start_point, end_point, full);
         if (phase == PHASE_COUNT - 1)
            idle_off <= 1'b1;
         for (int item = 0; item < PHASE_ITEMS; item++) begin
            if (phase == 4 && item == 30)
               hold_requests <= hold_requests + 1;
            push_transaction(pick_torque(), pick_measured());
         end
      end

      drain_pipe();
      repeat (DATA_WIDTH + 4) @(negedge clock);
      if (fail_count == 0 && outstanding == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
